FILE: hdl/pcsm_pkg.sv
// shared types, constants and helpers of the power channel switch manager
package pcsm_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int VAL_W = 16;
	localparam int PRIO_W = 3;
	localparam int LIM_PER_CH = 4;
	localparam int LIM_ENTRIES = NUM_CHANNELS * LIM_PER_CH;
	localparam int LIM_AW = $clog2(LIM_ENTRIES);
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DIS_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL = 2'd2;

	localparam logic [1:0] LIM_ON  = 2'd0;
	localparam logic [1:0] LIM_OFF = 2'd1;
	localparam logic [1:0] LIM_MAX = 2'd2;
	localparam logic [1:0] LIM_MIN = 2'd3;

	localparam logic [VAL_W-1:0] MODE_TOP  = 16'd1;
	localparam logic [VAL_W-1:0] MODE_FULL = 16'd2;
	localparam logic [VAL_W-1:0] PRIO_MAX  = 16'd7;

	typedef enum logic [2:0] {
		OP_SET_PRIORITY = 3'd0,
		OP_SET_LIMIT    = 3'd1,
		OP_GROUP        = 3'd2,
		OP_SET_MODE     = 3'd3,
		OP_BATT_VOLT    = 3'd4,
		OP_BATT_CURR    = 3'd5,
		OP_CHAN_VOLT    = 3'd6,
		OP_RESUME       = 3'd7
	} op_t;

	typedef logic [NUM_CHANNELS-1:0] chmask_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [CH_W-1:0]  channel;
		logic [CH_W-1:0]  second_channel;
		logic [1:0]       limit_select;
		logic [VAL_W-1:0] value;
		logic             discharging;
	} item_t;

	typedef struct packed {
		logic [7:0]      switch_states;
		logic [7:0]      enabled_states;
		logic [7:0]      resume_states;
		logic            shed_valid;
		logic [CH_W-1:0] shed_channel;
	} result_t;

	typedef struct packed {
		op_t               op;
		logic [CH_W-1:0]   ch;
		logic [CH_W-1:0]   ch2;
		logic [1:0]        sel;
		logic [VAL_W-1:0]  value;
		logic [PRIO_W-1:0] prio;
		logic              shed_req;
	} cmd_t;

	typedef struct packed {
		logic [PRIO_W-1:0] top_level;
		logic [PRIO_W-1:0] low_level;
	} levels_t;

endpackage

FILE: hdl/power_channel_switch_manager.sv
// top level of the power channel switch manager: config registers, front and back ends
// the back end takes one command at a time; table, group, mode and resume events go straight
// to the output, battery voltage reads the on and if needed the off limit, battery current
// scans every channel only when it sheds, and channel voltage does two limit ram reads per
// channel in the window check; a 2-entry command queue takes items while the back end works
// reset: all switch, enable and resume bits clear, groups hold only their own channel,
// tables read as zero until written, registers at their reset values; no clearing pass
module power_channel_switch_manager #(
	parameter int QUEUE_DEPTH = pcsm_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  pcsm_pkg::item_t                   item,
	output logic                              empty,
	input  logic                              pop,
	output pcsm_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcsm_pkg::VAL_W-1:0]        cfg_data
);
	import pcsm_pkg::*;

	logic [VAL_W-1:0] dis_limit_q;
	levels_t          levels_q;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dis_limit_q        <= '1;
			levels_q.top_level <= '1;
			levels_q.low_level <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIS_LIMIT: dis_limit_q        <= cfg_data;
				CFG_TOP_LEVEL: levels_q.top_level <= cfg_data[PRIO_W-1:0];
				CFG_LOW_LEVEL: levels_q.low_level <= cfg_data[PRIO_W-1:0];
				default: ;
			endcase
		end
	end

	pcsm_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.dis_limit(dis_limit_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	pcsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.levels   (levels_q),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	a_shed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.shed_valid) |-> (result.shed_channel == '0))
		else $error("shed channel set without shed");

	a_shed_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.shed_valid) |-> result.resume_states[result.shed_channel])
		else $error("shed channel not pending resume");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

FILE: hdl/pcsm_ram.sv
// generic single write port ram with registered read
module pcsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/pcsm_front.sv
// front end: accepts items, classifies them and queues commands for the back end
module pcsm_front #(
	parameter int DEPTH = pcsm_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  pcsm_pkg::item_t                item,
	input  logic [pcsm_pkg::VAL_W-1:0]     dis_limit,
	output logic                           cmd_valid,
	output pcsm_pkg::cmd_t                 cmd,
	input  logic                           cmd_take
);
	import pcsm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cls;
	logic             wr_en;
	logic             rd_en;

	always_comb begin
		cls.op       = op_t'(item.op);
		cls.ch       = item.channel;
		cls.ch2      = item.second_channel;
		cls.sel      = item.limit_select;
		cls.value    = item.value;
		cls.prio     = (item.value > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : item.value[PRIO_W-1:0];
		cls.shed_req = item.discharging && (item.value > dis_limit);
	end

	assign full      = (cnt_q == CNT_FULL);
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/pcsm_back.sv
// back end: channel state, sequencer for scans and the result register
module pcsm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  pcsm_pkg::cmd_t    cmd,
	output logic              cmd_take,
	input  pcsm_pkg::levels_t levels,
	output logic              empty,
	input  logic              pop,
	output pcsm_pkg::result_t result
);
	import pcsm_pkg::*;

	localparam logic [CH_W-1:0] IDX_LAST = CH_W'(NUM_CHANNELS - 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_LIM_ON  = 7'b0000010,
		ST_LIM_OFF = 7'b0000100,
		ST_SHED    = 7'b0001000,
		ST_WIN_MAX = 7'b0010000,
		ST_WIN_MIN = 7'b0100000,
		ST_OUT     = 7'b1000000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	chmask_t             switch_q;
	chmask_t             enable_q;
	chmask_t             resume_q;
	chmask_t             group_q [NUM_CHANNELS];
	logic [PRIO_W-1:0]   prio_q [NUM_CHANNELS];
	logic [VAL_W-1:0]    volts_q [NUM_CHANNELS];
	logic [LIM_ENTRIES-1:0] lim_vld_q;
	logic                rd_vld_q;
	logic [CH_W-1:0]     idx_q;
	logic [CH_W-1:0]     low_q;
	logic                shed_v_q;
	logic [VAL_W-1:0]    max_q;
	result_t             out_q;
	logic                out_full_q;

	logic                ram_we;
	logic [LIM_AW-1:0]   ram_waddr;
	logic [LIM_AW-1:0]   ram_raddr;
	logic [VAL_W-1:0]    ram_rdata;
	logic [VAL_W-1:0]    lim;
	logic                slot_free;
	chmask_t             col_ch;
	chmask_t             col_idx;
	chmask_t             col_cand;
	chmask_t             col_resume;
	chmask_t             mode_en;
	logic [CH_W-1:0]     cand;
	logic                trip;

	function automatic chmask_t group_col(input chmask_t masks [NUM_CHANNELS],
			input logic [CH_W-1:0] c);
		chmask_t m;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			m[i] = masks[i][c];
		end
		return m;
	endfunction

	assign slot_free = !out_full_q || pop;
	assign cmd_take  = (state_q == ST_IDLE) && cmd_valid;
	assign empty     = !out_full_q;
	assign result    = out_q;
	assign lim       = rd_vld_q ? ram_rdata : '0;

	assign ram_we    = cmd_take && (cmd.op == OP_SET_LIMIT);
	assign ram_waddr = {cmd.ch, cmd.sel};

	always_comb begin
		case (state_q)
			ST_IDLE:    ram_raddr = (cmd.op == OP_CHAN_VOLT) ? {CH_W'(0), LIM_MAX}
			                                                 : {cmd.ch, LIM_ON};
			ST_LIM_ON:  ram_raddr = {cmd_q.ch, LIM_OFF};
			ST_WIN_MAX: ram_raddr = {idx_q, LIM_MIN};
			ST_WIN_MIN: ram_raddr = {idx_q + 1'b1, LIM_MAX};
			default:    ram_raddr = {cmd_q.ch, LIM_ON};
		endcase
	end

	always_comb begin
		col_ch   = group_col(group_q, cmd_q.ch);
		col_idx  = group_col(group_q, idx_q);
		cand     = (enable_q[idx_q] && (prio_q[idx_q] <= prio_q[low_q])) ? idx_q : low_q;
		col_cand = group_col(group_q, cand);
		trip     = enable_q[idx_q] && ((volts_q[idx_q] > max_q) || (volts_q[idx_q] < lim));
		col_resume = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (enable_q[i] && resume_q[i]) begin
				col_resume = col_resume | group_col(group_q, CH_W'(i));
			end
			if (cmd.value == MODE_TOP) begin
				mode_en[i] = (prio_q[i] == levels.top_level);
			end else if (cmd.value == MODE_FULL) begin
				mode_en[i] = (prio_q[i] >= levels.low_level);
			end else begin
				mode_en[i] = 1'b0;
			end
		end
	end

	pcsm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(LIM_ENTRIES)
	) u_lim_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_WIN_MAX) begin
			max_q <= lim;
		end
		if ((state_q == ST_OUT) && slot_free) begin
			out_q.switch_states  <= switch_q;
			out_q.enabled_states <= enable_q;
			out_q.resume_states  <= resume_q;
			out_q.shed_valid     <= shed_v_q;
			out_q.shed_channel   <= low_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			switch_q   <= '0;
			enable_q   <= '0;
			resume_q   <= '0;
			lim_vld_q  <= '0;
			rd_vld_q   <= 1'b0;
			idx_q      <= '0;
			low_q      <= '0;
			shed_v_q   <= 1'b0;
			out_full_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				group_q[i] <= chmask_t'(1) << i;
				prio_q[i]  <= '0;
				volts_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= lim_vld_q[ram_raddr];
			if ((state_q == ST_OUT) && slot_free) begin
				out_full_q <= 1'b1;
			end else if (pop && out_full_q) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q    <= '0;
						low_q    <= '0;
						shed_v_q <= 1'b0;
						case (cmd.op)
							OP_SET_PRIORITY: begin
								prio_q[cmd.ch] <= cmd.prio;
								state_q        <= ST_OUT;
							end
							OP_SET_LIMIT: begin
								lim_vld_q[{cmd.ch, cmd.sel}] <= 1'b1;
								state_q                      <= ST_OUT;
							end
							OP_GROUP: begin
								for (int i = 0; i < NUM_CHANNELS; i++) begin
									if (group_q[i][cmd.ch] || group_q[i][cmd.ch2]) begin
										group_q[i][cmd.ch]  <= 1'b1;
										group_q[i][cmd.ch2] <= 1'b1;
									end
								end
								state_q <= ST_OUT;
							end
							OP_SET_MODE: begin
								if (cmd.value <= MODE_FULL) begin
									enable_q <= mode_en;
								end
								state_q <= ST_OUT;
							end
							OP_BATT_VOLT: begin
								if (enable_q[cmd.ch]) begin
									state_q <= ST_LIM_ON;
								end else begin
									state_q <= ST_OUT;
								end
							end
							OP_BATT_CURR: begin
								if (cmd.shed_req) begin
									state_q <= ST_SHED;
								end else begin
									state_q <= ST_OUT;
								end
							end
							OP_CHAN_VOLT: begin
								if (switch_q[cmd.ch]) begin
									volts_q[cmd.ch] <= cmd.value;
								end
								state_q <= ST_WIN_MAX;
							end
							OP_RESUME: begin
								switch_q <= switch_q | col_resume;
								resume_q <= resume_q & ~enable_q;
								state_q  <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_LIM_ON: begin
					if (cmd_q.value >= lim) begin
						switch_q <= switch_q | col_ch;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_LIM_OFF;
					end
				end
				ST_LIM_OFF: begin
					if (cmd_q.value < lim) begin
						switch_q <= switch_q & ~col_ch;
					end
					state_q <= ST_OUT;
				end
				ST_SHED: begin
					low_q <= cand;
					if (idx_q == IDX_LAST) begin
						switch_q       <= switch_q & ~col_cand;
						resume_q[cand] <= 1'b1;
						shed_v_q       <= 1'b1;
						state_q        <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WIN_MAX: state_q <= ST_WIN_MIN;
				ST_WIN_MIN: begin
					if (trip) begin
						switch_q        <= switch_q & ~col_idx;
						resume_q[idx_q] <= 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_WIN_MAX;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
